### rtl/packet_number_window_tracker_top_assert.svh
// assertion macros for the packet number window tracker
// used at the end of packet_number_window_tracker_top, expects i_clk and i_rst_n in scope
`ifndef PACKET_NUMBER_WINDOW_TRACKER_TOP_ASSERT_SVH
`define PACKET_NUMBER_WINDOW_TRACKER_TOP_ASSERT_SVH

// condition in the same cycle
`define PNWT_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pnwt check failed");

// condition in the following cycle
`define PNWT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pnwt check failed");

`endif

### rtl/pnwt_pkg.sv
// shared widths and types for the packet number window tracker
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package pnwt_pkg;

    localparam int PN_W  = 62;
    localparam int RUN_W = 7;

    typedef logic [PN_W-1:0]  t_pn;
    typedef logic [RUN_W-1:0] t_run;

    // status of the tracker for the item being recorded
    typedef struct packed {
        logic seen;
        logic recorded;
    } t_pnwt_upd;

endpackage

`default_nettype wire

### rtl/pnwt_update.sv
// tracker state (largest number, window bitmap) with its registered update
// depends on pnwt_pkg
`timescale 1ns / 1ps
`default_nettype none

module pnwt_update import pnwt_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_en,
    input  wire t_pn               i_pn,
    output t_pnwt_upd              o_upd,
    output t_pn                    o_largest,
    output logic [WINDOW-1:0]      o_win
);

    localparam int IW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam logic [WINDOW-1:0] ONE = WINDOW'(1);

    t_pn               r_largest, n_largest;
    logic [WINDOW-1:0] r_win, n_win;
    logic              r_rec, n_rec;

    t_pn               d_up, d_dn, um1, dm1;
    logic              gt, eq, up_shift_ok, up_near, dn_near, seen;
    logic [WINDOW-1:0] shifted, old_mark, dn_mark;

    always_comb begin
        gt          = i_pn > r_largest;
        eq          = i_pn == r_largest;
        d_up        = i_pn - r_largest;
        d_dn        = r_largest - i_pn;
        um1         = d_up - t_pn'(1);
        dm1         = d_dn - t_pn'(1);
        up_shift_ok = d_up < PN_W'(WINDOW);
        up_near     = d_up <= PN_W'(WINDOW);
        dn_near     = !gt && !eq && (d_dn <= PN_W'(WINDOW));

        shifted  = up_shift_ok ? (r_win << d_up[IW-1:0]) : '0;
        old_mark = up_near ? (ONE << um1[IW-1:0]) : '0;
        dn_mark  = ONE << dm1[IW-1:0];

        seen = r_rec && (eq || (dn_near && (|(r_win & dn_mark))));

        n_largest = r_largest;
        n_win     = r_win;
        n_rec     = r_rec;
        if (!r_rec) begin
            n_largest = i_pn;
            n_rec     = 1'b1;
        end else if (gt) begin
            // slide up and mark the previous largest
            n_largest = i_pn;
            n_win     = shifted | old_mark;
        end else if (dn_near) begin
            n_win = r_win | dn_mark;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_largest <= '0;
            r_win     <= '0;
            r_rec     <= 1'b0;
        end else if (i_en) begin
            r_largest <= n_largest;
            r_win     <= n_win;
            r_rec     <= n_rec;
        end
    end

    assign o_upd     = '{seen: seen, recorded: r_rec};
    assign o_largest = n_largest;
    assign o_win     = n_win;

endmodule

`default_nettype wire

### rtl/pnwt_run.sv
// trailing-ones count of the window bitmap, capped at the window size
// depends on pnwt_pkg
`timescale 1ns / 1ps
`default_nettype none

module pnwt_run import pnwt_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  wire logic [WINDOW-1:0] i_win,
    output t_run                   o_run
);

    logic [WINDOW-1:0] zeros, lowest;
    t_run              pos;

    always_comb begin
        // isolate the lowest clear bit, then encode its position
        zeros  = ~i_win;
        lowest = zeros & (~zeros + WINDOW'(1));
        pos    = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (lowest[i]) begin
                pos = pos | RUN_W'(i);
            end
        end
        o_run = (|zeros) ? pos : RUN_W'(WINDOW);
    end

endmodule

`default_nettype wire

### rtl/packet_number_window_tracker_top.sv
// packet number window tracker: input register, state update, window register, result register
// depends on pnwt_pkg, pnwt_update, pnwt_run and packet_number_window_tracker_top_assert.svh
//
//   channel | valid       | ready        | payload
//   --------+-------------+--------------+-------------------------------------------------
//   in      | i_in_valid  | o_in_ready   | i_packet_number
//   out     | o_out_valid | i_out_ready  | o_already_seen, o_largest_number, o_run_below
//
// one item per cycle sustained while the output is not stalled; three register stages from input to result
// the largest/bitmap update is combinational from the input register, so items follow back to back
// the trailing-ones count runs one stage later on the registered bitmap
// reset clears the tracker state and all valid flags, nothing else to clear
// a stall on the output fills the stages, then in_ready drops
`timescale 1ns / 1ps
`default_nettype none

module packet_number_window_tracker_top import pnwt_pkg::*; #(
    parameter int WINDOW = 64
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_pn  i_packet_number,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output logic      o_already_seen,
    output t_pn       o_largest_number,
    output t_run      o_run_below
);

    logic              r_s_valid;
    t_pn               r_s_pn;

    logic              r_m_valid;
    logic              r_m_seen;
    t_pn               r_m_largest;
    logic [WINDOW-1:0] r_m_win;

    logic              r_o_valid;
    logic              r_o_seen;
    t_pn               r_o_largest;
    t_run              r_o_run;

    logic              out_take, m_adv, s_take, upd_en;
    t_pnwt_upd         upd;
    t_pn               upd_largest;
    logic [WINDOW-1:0] upd_win;
    t_run              run_cnt;

    assign out_take   = !r_o_valid || i_out_ready;
    assign m_adv      = !r_m_valid || out_take;
    assign s_take     = !r_s_valid || m_adv;
    assign upd_en     = r_s_valid && m_adv;
    assign o_in_ready = s_take;

    pnwt_update #(.WINDOW(WINDOW)) u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (upd_en),
        .i_pn      (r_s_pn),
        .o_upd     (upd),
        .o_largest (upd_largest),
        .o_win     (upd_win)
    );

    pnwt_run #(.WINDOW(WINDOW)) u_run (
        .i_win (r_m_win),
        .o_run (run_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s_valid <= 1'b0;
            r_m_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (s_take) begin
                r_s_valid <= i_in_valid;
            end
            if (m_adv) begin
                r_m_valid <= r_s_valid;
            end
            if (out_take) begin
                r_o_valid <= r_m_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take && i_in_valid) begin
            r_s_pn <= i_packet_number;
        end
        if (upd_en) begin
            r_m_seen    <= upd.seen;
            r_m_largest <= upd_largest;
            r_m_win     <= upd_win;
        end
        if (out_take && r_m_valid) begin
            r_o_seen    <= r_m_seen;
            r_o_largest <= r_m_largest;
            r_o_run     <= run_cnt;
        end
    end

    assign o_out_valid      = r_o_valid;
    assign o_already_seen   = r_o_seen;
    assign o_largest_number = r_o_largest;
    assign o_run_below      = r_o_run;

    `include "packet_number_window_tracker_top_assert.svh"

    `PNWT_ASSERT_SAME(a_run_capped, r_o_valid, r_o_run <= RUN_W'(WINDOW))
    `PNWT_ASSERT_SAME(a_seen_needs_history, r_s_valid && upd.seen, upd.recorded)
    `PNWT_ASSERT_NEXT(a_mid_reaches_out, r_m_valid && out_take, r_o_valid)

endmodule

`default_nettype wire

### tb/sv/tb_packet_number_window_tracker_top.sv
// self-checking tb for packet_number_window_tracker_top: table head, random items, table tail
// depends on pnwt_pkg, the tracker rtl; untyped items predicted from a local largest/bitmap copy
`timescale 1ns / 1ps

module tb_packet_number_window_tracker_top;
    import pnwt_pkg::*;

    localparam int WINDOW      = 64;
    localparam int HEAD_ROWS   = 17;
    localparam int TABLE_ROWS  = 25;
    localparam int RAND_ITEMS  = 1475;
    localparam int CALM_FROM   = 500;
    localparam int CALM_TO     = 800;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 10;
    localparam t_pn PN_MAX     = '1;

    typedef struct packed {
        logic seen;
        t_pn  largest;
        t_run run;
    } t_verdict;

    typedef struct packed {
        t_pn      pn;
        logic     typed;
        t_verdict want;
    } t_dir_row;

    logic i_clk;
    logic i_rst_n         = 1'b0;
    logic i_in_valid      = 1'b0;
    t_pn  i_packet_number = '0;
    logic i_out_ready     = 1'b0;
    logic o_in_ready;
    logic o_out_valid;
    logic o_already_seen;
    t_pn  o_largest_number;
    t_run o_run_below;

    // local copy of the tracker state
    t_pn         top_pn       = '0;
    logic [63:0] seen_map     = '0;
    logic        any_recorded = 1'b0;

    t_verdict pending_verdicts[$];
    t_dir_row dir_rows[TABLE_ROWS];
    bit       calm     = 1'b0;
    int       n_errors = 0;
    int       stall_cycles = 0;

    packet_number_window_tracker_top #(
        .WINDOW(WINDOW)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_packet_number (i_packet_number),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_already_seen  (o_already_seen),
        .o_largest_number(o_largest_number),
        .o_run_below     (o_run_below)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // check, then record; returns what the tracker should report for this number
    function automatic t_verdict track_number(t_pn pn);
        t_verdict    v;
        t_pn         d;
        logic [63:0] shifted;
        logic [63:0] mark;
        logic [63:0] win_mask;
        int          n;
        win_mask = {64{1'b1}} >> (64 - WINDOW);
        v.seen   = 1'b0;
        if (!any_recorded) begin
            any_recorded = 1'b1;
            top_pn       = pn;
        end else if (pn == top_pn) begin
            v.seen = 1'b1;
        end else if (pn > top_pn) begin
            d        = pn - top_pn;
            shifted  = (d >= 64) ? 64'd0 : (seen_map << d);
            mark     = (d <= WINDOW) ? (64'd1 << (d - 1)) : 64'd0;
            seen_map = (shifted | mark) & win_mask;
            top_pn   = pn;
        end else begin
            d = top_pn - pn;
            if (d <= WINDOW) begin
                v.seen                = seen_map[int'(d) - 1];
                seen_map[int'(d) - 1] = 1'b1;
            end
        end
        n = 0;
        while (n < WINDOW && seen_map[n]) n++;
        v.largest = top_pn;
        v.run     = t_run'(n);
        return v;
    endfunction

    function automatic bit idle_roll();
        return !calm && ($urandom_range(99) < 19);
    endfunction

    // mostly numbers around the current largest, some jumps and stale noise
    function automatic t_pn pick_number();
        int mode;
        int step;
        mode = $urandom_range(99);
        step = ($urandom_range(3) == 0) ? $urandom_range(2, 5) : 1;
        if (mode < 45) return top_pn + t_pn'(step);
        if (mode < 70) return top_pn - t_pn'($urandom_range(1, WINDOW));
        if (mode < 78) return top_pn;
        if (mode < 85) return top_pn + t_pn'($urandom_range(WINDOW - 4, WINDOW + 6));
        if (mode < 90) return top_pn - t_pn'($urandom_range(WINDOW + 1, 300));
        if (mode < 95) return t_pn'({$urandom, $urandom});
        return t_pn'($urandom_range(0, 200));
    endfunction

    task automatic offer_number(t_pn pn, logic typed, t_verdict want);
        t_verdict v;
        while (idle_roll()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_packet_number <= pn;
        do @(posedge i_clk); while (!o_in_ready);
        v = track_number(pn);
        pending_verdicts.push_back(typed ? want : v);
    endtask

    // result side: compare against the oldest expectation, then pick next ready
    always @(posedge i_clk) begin
        t_verdict exp_v;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_verdicts.size() == 0) begin
                $display("%0t: unexpected item, seen=%0b largest=%0h run=%0d", $realtime,
                         o_already_seen, o_largest_number, o_run_below);
                n_errors++;
            end else begin
                exp_v = pending_verdicts.pop_front();
                if (o_already_seen !== exp_v.seen) begin
                    $display("%0t: already_seen expected %0b actual %0b", $realtime,
                             exp_v.seen, o_already_seen);
                    n_errors++;
                end
                if (o_largest_number !== exp_v.largest) begin
                    $display("%0t: largest_number expected %0h actual %0h", $realtime,
                             exp_v.largest, o_largest_number);
                    n_errors++;
                end
                if (o_run_below !== exp_v.run) begin
                    $display("%0t: run_below expected %0d actual %0d", $realtime,
                             exp_v.run, o_run_below);
                    n_errors++;
                end
            end
        end
        i_out_ready <= !idle_roll();
    end

    // watchdog on cycles with no handshake on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
        if (stall_cycles == STALL_LIMIT) begin
            $display("[packet_number_window_tracker_top] ERROR");
            $finish;
        end
    end

    initial begin
        // pn, typed, {seen, largest, run}
        dir_rows = '{
            '{62'd0,   1'b1, '{1'b0, 62'd0,   7'd0}},   // first number
            '{62'd0,   1'b1, '{1'b1, 62'd0,   7'd0}},   // equal to largest
            '{62'd64,  1'b1, '{1'b0, 62'd64,  7'd0}},   // jump of exactly a window
            '{62'd0,   1'b1, '{1'b1, 62'd64,  7'd0}},   // oldest bit of the window
            '{62'd63,  1'b1, '{1'b0, 62'd64,  7'd1}},
            '{62'd62,  1'b1, '{1'b0, 62'd64,  7'd2}},
            '{62'd62,  1'b1, '{1'b1, 62'd64,  7'd2}},   // replay inside the window
            '{62'd65,  1'b0, '0},
            '{62'd200, 1'b1, '{1'b0, 62'd200, 7'd0}},   // jump past the window
            '{62'd135, 1'b1, '{1'b0, 62'd200, 7'd0}},   // just outside, ignored
            '{62'd136, 1'b1, '{1'b0, 62'd200, 7'd0}},
            '{62'd136, 1'b1, '{1'b1, 62'd200, 7'd0}},
            '{62'd199, 1'b1, '{1'b0, 62'd200, 7'd1}},
            '{62'd201, 1'b0, '0},
            '{62'd265, 1'b0, '0},
            '{62'h1555_5555_5555_5555, 1'b0, '0},
            '{62'h2AAA_AAAA_AAAA_AAAA, 1'b0, '0},
            '{PN_MAX,      1'b1, '{1'b0, PN_MAX, 7'd0}},
            '{PN_MAX - 1,  1'b1, '{1'b0, PN_MAX, 7'd1}},
            '{PN_MAX - 65, 1'b1, '{1'b0, PN_MAX, 7'd1}},
            '{PN_MAX - 64, 1'b0, '0},
            '{PN_MAX - 3,  1'b0, '0},
            '{PN_MAX - 2,  1'b0, '0},
            '{PN_MAX,      1'b0, '0},
            '{62'd0,       1'b0, '0}
        };
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int r = 0; r < HEAD_ROWS; r++) begin
            offer_number(dir_rows[r].pn, dir_rows[r].typed, dir_rows[r].want);
        end
        for (int k = 0; k < RAND_ITEMS; k++) begin
            calm = (k >= CALM_FROM) && (k < CALM_TO);
            offer_number(pick_number(), 1'b0, '0);
        end
        calm = 1'b0;
        // the largest number never comes down, so the ceiling rows go last
        for (int r = HEAD_ROWS; r < TABLE_ROWS; r++) begin
            offer_number(dir_rows[r].pn, dir_rows[r].typed, dir_rows[r].want);
        end
        i_in_valid <= 1'b0;
        while (pending_verdicts.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("[packet_number_window_tracker_top] OK");
        end else begin
            $display("[packet_number_window_tracker_top] ERROR");
        end
        $finish;
    end

endmodule
